// ===== rtl/core/ebcie_pkg.sv =====
// Shared types and constants for the 8-bit instruction execute block.
package ebcie_pkg;

    localparam int MemBytes = 65536;
    localparam int MemAw    = $clog2(MemBytes);
    localparam int MemCount = MemBytes;

    typedef enum logic [4:0] {
        OP_LDFM = 5'd0,  OP_LDFI = 5'd1,  OP_LDFR = 5'd2,  OP_STOR = 5'd3,
        OP_SWPR = 5'd4,  OP_SWPM = 5'd5,  OP_PULR = 5'd6,  OP_PSHR = 5'd7,
        OP_PSHM = 5'd8,  OP_PULC = 5'd9,  OP_PSHC = 5'd10, OP_PULF = 5'd11,
        OP_PSHF = 5'd12, OP_AND  = 5'd13, OP_EOR  = 5'd14, OP_ORA  = 5'd15,
        OP_NOT  = 5'd16, OP_ADD  = 5'd17, OP_SUB  = 5'd18, OP_JMP  = 5'd19,
        OP_HALT = 5'd20
    } t_op;

    localparam logic [15:0] PcReset = 16'hFFFD;

    typedef struct packed {
        logic [4:0]  op;
        logic [2:0]  first_reg;
        logic [2:0]  second_reg;
        logic [7:0]  immediate;
        logic [15:0] first_address;
        logic [15:0] second_address;
        logic [2:0]  len;
    } t_instr;

    typedef struct packed {
        logic [15:0] program_counter;
        logic        carry_flag;
        logic        zero_flag;
        logic        overflow_flag;
        logic        sign_flag;
        logic [7:0]  dest_value;
        logic        halted;
    } t_result;

    function automatic logic [2:0] instr_len(input logic [4:0] op);
        logic [2:0] l;
        l = 3'd1;
        case (op)
            OP_LDFM, OP_STOR: l = 3'd4;
            OP_LDFI, OP_LDFR, OP_SWPR, OP_PSHM, OP_AND, OP_EOR, OP_ORA, OP_ADD: l = 3'd3;
            OP_SWPM: l = 3'd5;
            OP_PULR, OP_PSHR, OP_NOT: l = 3'd2;
            default: l = 3'd1;
        endcase
        return l;
    endfunction

endpackage

// ===== rtl/core/ebcie_if.sv =====
// Valid/ready channel interfaces for requests and results.
interface ebcie_in_if;
    logic                valid;
    logic                ready;
    logic [4:0]          op;
    logic [2:0]          first_reg;
    logic [2:0]          second_reg;
    logic [7:0]          immediate;
    logic [15:0]         first_address;
    logic [15:0]         second_address;
    modport source (output valid, op, first_reg, second_reg, immediate,
                    first_address, second_address, input ready);
    modport sink   (input valid, op, first_reg, second_reg, immediate,
                    first_address, second_address, output ready);
endinterface

interface ebcie_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] program_counter;
    logic        carry_flag;
    logic        zero_flag;
    logic        overflow_flag;
    logic        sign_flag;
    logic [7:0]  dest_value;
    logic        halted;
    modport source (output valid, program_counter, carry_flag, zero_flag,
                    overflow_flag, sign_flag, dest_value, halted, input ready);
    modport sink   (input valid, program_counter, carry_flag, zero_flag,
                    overflow_flag, sign_flag, dest_value, halted, output ready);
endinterface

// ===== rtl/core/eight_bit_cpu_instruction_execute_top.sv =====
// Top level of the 8-bit instruction execute block.
// Executes one decoded instruction per request and returns PC, flags, the
// first register's value and the halt mark. After reset the back end clears
// the 64 KiB byte memory, one byte a cycle; requests are queued but not
// executed until that pass ends. Register, immediate, jump, store and single
// push requests then finish in the idle state, back to back while results are
// taken; loads, pulls and memory push add a read state, PC push a write-back
// state, PC pull and memory swap a second read state and memory swap a final
// write-back state, all set by the single memory port. A two-entry queue
// separates request intake from execution; a result register holds each result.
module eight_bit_cpu_instruction_execute_top (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ebcie_in_if.sink    in_ch,
    ebcie_out_if.source out_ch
);
    logic              q_valid, q_take, be_busy;
    ebcie_pkg::t_instr q_instr;

    // Accept and length-tag requests.
    ebcie_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .o_valid(q_valid), .o_instr(q_instr), .i_take(q_take)
    );

    // Execute against registers and memory.
    ebcie_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_instr(q_instr),
        .o_take(q_take), .o_busy(be_busy), .out_ch(out_ch)
    );

    // A queue pop never happens while a multi-cycle instruction runs.
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        be_busy |-> !q_take) else $error("pop while busy");

    // Once halted, results keep reporting halt.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && out_ch.halted && out_ch.ready) ##1 out_ch.valid
        |-> out_ch.halted) else $error("halt lost");
endmodule

// ===== rtl/core/ebcie_front.sv =====
// Front end: accept requests, tag length, hold them in a two-entry queue.
module ebcie_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ebcie_in_if.sink             in_ch,
    output logic                 o_valid,
    output ebcie_pkg::t_instr    o_instr,
    input  logic                 i_take
);
    ebcie_pkg::t_instr r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       push;
    logic       pop;
    ebcie_pkg::t_instr n_in;

    assign in_ch.ready = (r_cnt != 2'd2);
    assign push = in_ch.valid && in_ch.ready;
    assign o_valid = (r_cnt != 2'd0);
    assign pop = o_valid && i_take;
    assign o_instr = r_q[r_rd];

    always_comb begin
        n_in.op             = in_ch.op;
        n_in.first_reg      = in_ch.first_reg;
        n_in.second_reg     = in_ch.second_reg;
        n_in.immediate      = in_ch.immediate;
        n_in.first_address  = in_ch.first_address;
        n_in.second_address = in_ch.second_address;
        n_in.len            = ebcie_pkg::instr_len(in_ch.op);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
            if (pop) r_rd <= ~r_rd;
        end
        if (push) r_q[r_rd ^ r_cnt[0]] <= n_in;
    end
endmodule

// ===== rtl/core/ebcie_back.sv =====
// Back end: sequencer that executes instructions against registers and memory.
module ebcie_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  ebcie_pkg::t_instr    i_instr,
    output logic                 o_take,
    output logic                 o_busy,
    ebcie_out_if.source          out_ch
);
    typedef enum logic [4:0] {
        S_CLR  = 5'b00001,
        S_IDLE = 5'b00010,
        S_RD1  = 5'b00100,
        S_RD2  = 5'b01000,
        S_WB   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [7:0]  r_rf [8];
    logic        r_c, r_z, r_v, r_s, r_halt;
    logic [15:0] r_sp, r_pc;
    logic [ebcie_pkg::MemAw-1:0] r_clr;
    logic [7:0]  mem [ebcie_pkg::MemCount];
    logic [7:0]  r_rdat;
    logic [7:0]  r_b1;
    ebcie_pkg::t_instr r_ins;
    logic        r_ovld;
    ebcie_pkg::t_result r_res;

    // memory port control (combinational)
    logic                        m_we, m_re;
    logic [ebcie_pkg::MemAw-1:0] m_wa, m_ra;
    logic [7:0]                  m_wd;

    logic out_free;
    assign out_free = !r_ovld || out_ch.ready;
    assign o_busy = (r_state != S_IDLE) && (r_state != S_CLR);

    logic [15:0] sp_dn, sp_dn2, sp_up, sp_up2;
    assign sp_dn  = r_sp - 16'd1;
    assign sp_dn2 = r_sp - 16'd2;
    assign sp_up  = r_sp + 16'd1;
    assign sp_up2 = r_sp + 16'd2;

    function automatic logic [ebcie_pkg::MemAw-1:0] ma(input logic [15:0] a);
        return a[ebcie_pkg::MemAw-1:0];
    endfunction

    // current item: from the queue in IDLE, otherwise the held copy
    ebcie_pkg::t_instr ci;
    assign ci = (r_state == S_IDLE) ? i_instr : r_ins;

    logic [7:0] ra_v, rb_v;
    assign ra_v = r_rf[ci.first_reg];
    assign rb_v = r_rf[ci.second_reg];

    logic        fin;
    logic [15:0] pc_nx;
    assign pc_nx = r_pc + {13'd0, ci.len};

    always_comb begin
        n_state = r_state;
        o_take  = 1'b0;
        m_we = 1'b0; m_re = 1'b0;
        m_wa = '0;   m_ra = '0;   m_wd = 8'd0;
        fin = 1'b0;
        case (r_state)
            S_CLR: begin
                m_we = 1'b1; m_wa = r_clr;
                if (r_clr == ebcie_pkg::MemAw'(ebcie_pkg::MemCount - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid && out_free) begin
                    o_take = 1'b1;
                    if (r_halt) begin
                        fin = 1'b1;
                    end else begin
                        case (i_instr.op)
                            ebcie_pkg::OP_LDFM, ebcie_pkg::OP_PSHM, ebcie_pkg::OP_SWPM: begin
                                m_re = 1'b1; m_ra = ma(i_instr.first_address);
                                n_state = S_RD1;
                            end
                            ebcie_pkg::OP_PULR, ebcie_pkg::OP_PULF: begin
                                m_re = 1'b1; m_ra = ma(sp_dn); n_state = S_RD1;
                            end
                            ebcie_pkg::OP_PULC: begin
                                m_re = 1'b1; m_ra = ma(sp_dn); n_state = S_RD1;
                            end
                            ebcie_pkg::OP_PSHC: begin
                                m_we = 1'b1; m_wa = ma(r_sp);
                                m_wd = pc_nx[7:0];
                                n_state = S_WB;
                            end
                            ebcie_pkg::OP_STOR: begin
                                m_we = 1'b1; m_wa = ma(i_instr.first_address); m_wd = ra_v;
                                fin = 1'b1;
                            end
                            ebcie_pkg::OP_PSHR: begin
                                m_we = 1'b1; m_wa = ma(r_sp); m_wd = ra_v; fin = 1'b1;
                            end
                            ebcie_pkg::OP_PSHF: begin
                                m_we = 1'b1; m_wa = ma(r_sp);
                                m_wd = {4'd0, r_s, r_v, r_z, r_c}; fin = 1'b1;
                            end
                            default: fin = 1'b1;
                        endcase
                    end
                end
            end
            S_RD1: begin
                case (r_ins.op)
                    ebcie_pkg::OP_SWPM: begin
                        m_re = 1'b1; m_ra = ma(r_ins.second_address); n_state = S_RD2;
                    end
                    ebcie_pkg::OP_PULC: begin
                        m_re = 1'b1; m_ra = ma(sp_dn2); n_state = S_RD2;
                    end
                    ebcie_pkg::OP_PSHM: begin
                        m_we = 1'b1; m_wa = ma(r_sp); m_wd = r_rdat; fin = 1'b1;
                        n_state = S_IDLE;
                    end
                    default: begin fin = 1'b1; n_state = S_IDLE; end
                endcase
            end
            S_RD2: begin
                if (r_ins.op == ebcie_pkg::OP_SWPM) begin
                    m_we = 1'b1; m_wa = ma(r_ins.first_address); m_wd = r_rdat;
                    n_state = S_WB;
                end else begin
                    fin = 1'b1; n_state = S_IDLE;
                end
            end
            S_WB: begin
                m_we = 1'b1;
                if (r_ins.op == ebcie_pkg::OP_SWPM) begin
                    m_wa = ma(r_ins.second_address); m_wd = r_b1;
                end else begin
                    m_wa = ma(sp_up); m_wd = pc_nx[15:8];
                end
                fin = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // architectural update at finish
    logic [7:0]  n_rf [8];
    logic        n_c, n_z, n_v, n_s, n_halt;
    logic [15:0] n_sp, n_pc;
    logic [8:0]  sum;
    always_comb begin
        for (int k = 0; k < 8; k++) n_rf[k] = r_rf[k];
        n_c = r_c; n_z = r_z; n_v = r_v; n_s = r_s; n_halt = r_halt;
        n_sp = r_sp; n_pc = r_pc;
        sum = {1'b0, ra_v} + {1'b0, rb_v} + {8'd0, r_c};
        if (fin && !r_halt) begin
            n_pc = pc_nx;
            case (ci.op)
                ebcie_pkg::OP_LDFM: n_rf[ci.first_reg] = r_rdat;
                ebcie_pkg::OP_LDFI: n_rf[ci.first_reg] = ci.immediate;
                ebcie_pkg::OP_LDFR: n_rf[ci.first_reg] = rb_v;
                ebcie_pkg::OP_SWPR: begin
                    n_rf[7] = ra_v;
                    n_rf[ci.first_reg] = (ci.second_reg == 3'd7) ? ra_v : rb_v;
                    n_rf[ci.second_reg] = (ci.first_reg == 3'd7) ?
                                          n_rf[ci.first_reg] : ra_v;
                end
                ebcie_pkg::OP_SWPM: begin
                    n_rf[6] = r_b1; n_rf[7] = r_rdat;
                end
                ebcie_pkg::OP_PULR: begin
                    n_rf[ci.first_reg] = r_rdat; n_sp = sp_dn;
                end
                ebcie_pkg::OP_PSHR, ebcie_pkg::OP_PSHM, ebcie_pkg::OP_PSHF: n_sp = sp_up;
                ebcie_pkg::OP_PSHC: n_sp = sp_up2;
                ebcie_pkg::OP_PULC: begin
                    n_sp = sp_dn2; n_pc = {r_b1, r_rdat};
                end
                ebcie_pkg::OP_PULF: begin
                    n_sp = sp_dn;
                    n_c = r_rdat[0]; n_z = r_rdat[1]; n_v = r_rdat[2]; n_s = r_rdat[3];
                end
                ebcie_pkg::OP_AND: n_rf[ci.first_reg] = ra_v & rb_v;
                ebcie_pkg::OP_EOR: n_rf[ci.first_reg] = ra_v ^ rb_v;
                ebcie_pkg::OP_ORA: n_rf[ci.first_reg] = ra_v | rb_v;
                ebcie_pkg::OP_NOT: n_rf[ci.first_reg] = ~ra_v;
                ebcie_pkg::OP_ADD: begin
                    n_rf[ci.first_reg] = sum[7:0];
                    n_c = sum[8];
                    n_v = (ra_v[7] == rb_v[7]) &&
                          (sum[7] != n_rf[ci.second_reg][7]);
                end
                ebcie_pkg::OP_JMP:  n_pc = ci.first_address;
                ebcie_pkg::OP_HALT: n_halt = 1'b1;
                default: ;
            endcase
            case (ci.op)
                ebcie_pkg::OP_LDFM, ebcie_pkg::OP_LDFI, ebcie_pkg::OP_PULR,
                ebcie_pkg::OP_AND, ebcie_pkg::OP_EOR, ebcie_pkg::OP_ORA,
                ebcie_pkg::OP_NOT, ebcie_pkg::OP_ADD: begin
                    n_s = n_rf[ci.first_reg][7];
                    n_z = (n_rf[ci.first_reg] == 8'd0);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_we) mem[m_wa] <= m_wd;
        if (m_re) r_rdat <= mem[m_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_ovld  <= 1'b0;
            r_c <= 1'b0; r_z <= 1'b0; r_v <= 1'b0; r_s <= 1'b0; r_halt <= 1'b0;
            r_sp <= 16'd0;
            r_pc <= ebcie_pkg::PcReset;
            for (int k = 0; k < 8; k++) r_rf[k] <= 8'd0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) r_clr <= r_clr + 1'b1;
            for (int k = 0; k < 8; k++) r_rf[k] <= n_rf[k];
            r_c <= n_c; r_z <= n_z; r_v <= n_v; r_s <= n_s; r_halt <= n_halt;
            r_sp <= n_sp; r_pc <= n_pc;
            if (fin) r_ovld <= 1'b1;
            else if (out_ch.ready) r_ovld <= 1'b0;
        end
        if (o_take) r_ins <= i_instr;
        if (r_state == S_RD1) r_b1 <= r_rdat;
        if (fin) begin
            r_res.program_counter <= n_pc;
            r_res.carry_flag      <= n_c;
            r_res.zero_flag       <= n_z;
            r_res.overflow_flag   <= n_v;
            r_res.sign_flag       <= n_s;
            r_res.dest_value      <= n_rf[ci.first_reg];
            r_res.halted          <= n_halt;
        end
    end

    assign out_ch.valid           = r_ovld;
    assign out_ch.program_counter = r_res.program_counter;
    assign out_ch.carry_flag      = r_res.carry_flag;
    assign out_ch.zero_flag       = r_res.zero_flag;
    assign out_ch.overflow_flag   = r_res.overflow_flag;
    assign out_ch.sign_flag       = r_res.sign_flag;
    assign out_ch.dest_value      = r_res.dest_value;
    assign out_ch.halted          = r_res.halted;
endmodule
